// ===== hdl/npps_pkg.sv =====
// ----------------------------------------------------------------------------
// npps_pkg
// Shared types and constants of the non-preemptive priority scheduler:
// request and status codes, controller states and parameter defaults.
// ----------------------------------------------------------------------------
package npps_pkg;

  localparam int READY_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 8;
  localparam int BURST_WIDTH_DEF = 16;

  localparam logic [15:0] TIME_MAX = 16'hFFFF;

  localparam logic REQ_ADMIT = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_ZERO = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE,
    ST_TICK
  } sched_state_t;

endpackage

// ===== hdl/nonpreemptive_priority_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler_unit
// Admit and tick without dispatch: accepted in idle, result strobed on the next cycle.
// Tick with dispatch: busy for a minimum scan over the ready entries (one table
// read per cycle), then one move per entry behind the winner, then the tick.
// The receiver cannot stall; out_valid pulses for one cycle per transfer.
// Synchronous active-low reset empties the table, idles the processor, time 0.
// ----------------------------------------------------------------------------
module nonpreemptive_priority_scheduler_unit
  import npps_pkg::*;
#(
  parameter int READY_DEPTH = READY_DEPTH_DEF,
  parameter int ID_WIDTH    = ID_WIDTH_DEF,
  parameter int BURST_WIDTH = BURST_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [7:0]  in_proc_id,
  input  logic [7:0]  in_prio_level,
  input  logic [15:0] in_burst_len,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tick_time,
  output logic        out_running_valid,
  output logic [7:0]  out_running_id,
  output logic        out_first_dispatch,
  output logic        out_finished,
  output logic [16:0] out_finish_time
);

  localparam int AW = $clog2(READY_DEPTH);
  localparam int CW = $clog2(READY_DEPTH + 1);

  typedef struct packed {
    logic [ID_WIDTH-1:0]    id;
    logic [7:0]             prio;
    logic [BURST_WIDTH-1:0] burst;
  } entry_t;

  entry_t mem [READY_DEPTH];
  entry_t rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;

  sched_state_t state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   run_active_r, run_active_nxt;
  logic [ID_WIDTH-1:0]    run_id_r, run_id_nxt;
  logic [BURST_WIDTH-1:0] run_left_r, run_left_nxt;
  logic [15:0]            time_r, time_nxt;

  logic [AW-1:0]          cmp_idx_r, cmp_idx_nxt;
  logic [AW-1:0]          best_idx_r, best_idx_nxt;
  logic [7:0]             best_prio_r, best_prio_nxt;
  logic [ID_WIDTH-1:0]    best_id_r, best_id_nxt;
  logic [BURST_WIDTH-1:0] best_burst_r, best_burst_nxt;
  logic [AW-1:0]          mv_idx_r, mv_idx_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [15:0] out_tick_time_r, out_tick_time_nxt;
  logic        out_running_valid_r, out_running_valid_nxt;
  logic [7:0]  out_running_id_r, out_running_id_nxt;
  logic        out_first_dispatch_r, out_first_dispatch_nxt;
  logic        out_finished_r, out_finished_nxt;
  logic [16:0] out_finish_time_r, out_finish_time_nxt;

  logic                      in_fire;
  logic [ID_WIDTH+7:0]       id_in_ext;
  logic [ID_WIDTH-1:0]       id_in;
  logic [BURST_WIDTH+15:0]   burst_in_ext;
  logic [BURST_WIDTH-1:0]    burst_in;
  logic [ID_WIDTH+7:0]       run_id_ext;
  logic [BURST_WIDTH-1:0]    left_dec;
  logic                      run_fin;
  logic [15:0]               time_inc;
  logic                      take;
  logic [AW-1:0]             sel_idx;
  logic [7:0]                sel_prio;
  logic [ID_WIDTH-1:0]       sel_id;
  logic [BURST_WIDTH-1:0]    sel_burst;
  logic                      scan_last;
  logic                      move_last;
  logic                      need_move;
  logic                      dispatch;

  assign busy    = (state_r != ST_IDLE);
  assign in_fire = start && !busy;

  assign id_in_ext    = {{ID_WIDTH{1'b0}}, in_proc_id};
  assign id_in        = id_in_ext[ID_WIDTH-1:0];
  assign burst_in_ext = {{BURST_WIDTH{1'b0}}, in_burst_len};
  assign burst_in     = burst_in_ext[BURST_WIDTH-1:0];
  assign run_id_ext   = {8'h00, run_id_r};

  assign left_dec = run_left_r - {{(BURST_WIDTH-1){1'b0}}, 1'b1};
  assign run_fin  = run_active_r && (left_dec == '0);
  assign time_inc = (time_r != TIME_MAX) ? time_r + 16'd1 : time_r;

  assign take      = (cmp_idx_r == '0) || (rd_data_r.prio < best_prio_r);
  assign sel_idx   = take ? cmp_idx_r       : best_idx_r;
  assign sel_prio  = take ? rd_data_r.prio  : best_prio_r;
  assign sel_id    = take ? rd_data_r.id    : best_id_r;
  assign sel_burst = take ? rd_data_r.burst : best_burst_r;
  assign scan_last = (CW'(cmp_idx_r) == count_r - CW'(1));
  assign need_move = (CW'(sel_idx) < count_r - CW'(1));
  assign move_last = (CW'(mv_idx_r) == count_r - CW'(1));
  assign dispatch  = !run_active_r && (count_r != '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_req_type == REQ_TICK) && dispatch) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = need_move ? ST_MOVE : ST_TICK;
        end
      end
      ST_MOVE: begin
        if (move_last) begin
          state_nxt = ST_TICK;
        end
      end
      ST_TICK: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    run_active_nxt = run_active_r;
    run_id_nxt     = run_id_r;
    run_left_nxt   = run_left_r;
    time_nxt       = time_r;
    cmp_idx_nxt    = cmp_idx_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_id_nxt    = best_id_r;
    best_burst_nxt = best_burst_r;
    mv_idx_nxt     = mv_idx_r;
    rd_addr        = '0;
    mem_we         = 1'b0;
    mem_waddr      = count_r[AW-1:0];
    mem_wdata      = '{id: id_in, prio: in_prio_level, burst: burst_in};

    out_valid_nxt          = 1'b0;
    out_status_nxt         = STATUS_OK;
    out_tick_time_nxt      = time_r;
    out_running_valid_nxt  = 1'b0;
    out_running_id_nxt     = 8'h00;
    out_first_dispatch_nxt = 1'b0;
    out_finished_nxt       = 1'b0;
    out_finish_time_nxt    = 17'd0;

    unique case (state_r)
      ST_IDLE: begin
        cmp_idx_nxt = '0;
        if (in_fire && (in_req_type == REQ_ADMIT)) begin
          out_valid_nxt = 1'b1;
          if (burst_in == '0) begin
            out_status_nxt = STATUS_ZERO;
          end else if (count_r == CW'(READY_DEPTH)) begin
            out_status_nxt = STATUS_FULL;
          end else begin
            mem_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end else if (in_fire && !dispatch) begin
          out_valid_nxt         = 1'b1;
          time_nxt              = time_inc;
          out_running_valid_nxt = run_active_r;
          if (run_active_r) begin
            out_running_id_nxt = run_id_ext[7:0];
            run_left_nxt       = left_dec;
          end
          if (run_fin) begin
            out_finished_nxt    = 1'b1;
            out_finish_time_nxt = {1'b0, time_r} + 17'd1;
            run_active_nxt      = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        best_idx_nxt   = sel_idx;
        best_prio_nxt  = sel_prio;
        best_id_nxt    = sel_id;
        best_burst_nxt = sel_burst;
        cmp_idx_nxt    = cmp_idx_r + AW'(1);
        rd_addr        = cmp_idx_r + AW'(1);
        if (scan_last) begin
          run_active_nxt = 1'b1;
          run_id_nxt     = sel_id;
          run_left_nxt   = sel_burst;
          count_nxt      = count_r - CW'(1);
          mv_idx_nxt     = sel_idx;
          rd_addr        = sel_idx + AW'(1);
        end
      end
      ST_MOVE: begin
        mem_we     = 1'b1;
        mem_waddr  = mv_idx_r;
        mem_wdata  = rd_data_r;
        mv_idx_nxt = mv_idx_r + AW'(1);
        rd_addr    = mv_idx_r + AW'(2);
      end
      ST_TICK: begin
        out_valid_nxt          = 1'b1;
        out_first_dispatch_nxt = 1'b1;
        out_running_valid_nxt  = 1'b1;
        out_running_id_nxt     = run_id_ext[7:0];
        run_left_nxt           = left_dec;
        time_nxt               = time_inc;
        if (run_fin) begin
          out_finished_nxt    = 1'b1;
          out_finish_time_nxt = {1'b0, time_r} + 17'd1;
          run_active_nxt      = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      run_active_r <= 1'b0;
      run_id_r     <= '0;
      run_left_r   <= '0;
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      run_active_r <= run_active_nxt;
      run_id_r     <= run_id_nxt;
      run_left_r   <= run_left_nxt;
      time_r       <= time_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r            <= cmp_idx_nxt;
    best_idx_r           <= best_idx_nxt;
    best_prio_r          <= best_prio_nxt;
    best_id_r            <= best_id_nxt;
    best_burst_r         <= best_burst_nxt;
    mv_idx_r             <= mv_idx_nxt;
    out_status_r         <= out_status_nxt;
    out_tick_time_r      <= out_tick_time_nxt;
    out_running_valid_r  <= out_running_valid_nxt;
    out_running_id_r     <= out_running_id_nxt;
    out_first_dispatch_r <= out_first_dispatch_nxt;
    out_finished_r       <= out_finished_nxt;
    out_finish_time_r    <= out_finish_time_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_tick_time      = out_tick_time_r;
  assign out_running_valid  = out_running_valid_r;
  assign out_running_id     = out_running_id_r;
  assign out_first_dispatch = out_first_dispatch_r;
  assign out_finished       = out_finished_r;
  assign out_finish_time    = out_finish_time_r;

`ifndef ASSERT_OFF
  a_admit_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_ADMIT)) |=> out_valid)
    else $error("admit transfer without a result on the next cycle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(READY_DEPTH))
    else $error("ready count beyond table depth");

  a_first_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_first_dispatch) |-> (out_running_valid && (out_status == STATUS_OK)))
    else $error("dispatch reported without a running process");

  a_finish_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_finished) |-> (out_finish_time == {1'b0, out_tick_time} + 17'd1))
    else $error("finish time does not follow tick time");
`endif

endmodule
